[src/mpd_pkg.sv]
// mpd_pkg: shared types and constants for the mouse packet decoder
// depends on nothing; used by every module of the decoder

package mpd_pkg;

    // result kinds as shown on event_kind
    typedef enum logic [1:0] {
        EV_RAW     = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_MOVE    = 2'd3
    } event_kind_t;

    // position of the next byte inside a packet
    typedef enum logic [1:0] {
        POS_STATUS = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

    // slots of the pending-result mask, in output order
    localparam int NUM_SLOTS     = 8;
    localparam int SLOT_W        = 3;
    localparam int SLOT_ECHO     = 0;
    localparam int SLOT_PRESS0   = 1;
    localparam int SLOT_RELEASE0 = 4;
    localparam int SLOT_MOVE     = 7;
    localparam int NUM_BUTTONS   = 3;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // one classified word handed from front to back
    typedef struct packed {
        logic [NUM_SLOTS-1:0] pend;
        logic [7:0]           raw;
        logic signed [8:0]    dx;
        logic signed [8:0]    dy;
    } job_t;

endpackage

[src/mouse_packet_decoder_core.sv]
// Mouse packet decoder: takes one byte a word from the mouse port, builds
// status/X/Y packets and returns for every byte a raw echo, then for a
// completing Y byte the button presses (1 to 3), releases (1 to 3) and a
// move event with 9-bit signed deltas when either is nonzero; last_of_run
// marks the final word caused by a byte. Both sides behave as queues.
// The front takes one byte per cycle while the job queue has room; the back
// issues one result word per cycle unless a word waits unpopped; a plain
// byte gives its echo alone, a completing byte also its button and move words.
// The first result passes the job queue, pending mask and output register.

module mouse_packet_decoder_core
    import mpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        event_kind,
    output logic [1:0]        button_number,
    output logic [7:0]        raw_byte,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              last_of_run
);

    logic q_full, q_empty, q_read, job_write, accept, out_valid;
    job_t job, q_data;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    // front: byte classification
    mpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .job_write (job_write),
        .job       (job)
    );

    // job queue
    mpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_write),
        .wr_data (job),
        .full    (q_full),
        .rd_en   (q_read),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back: result serializer
    mpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_read        (q_read),
        .out_valid     (out_valid),
        .out_take      (pop),
        .event_kind    (event_kind),
        .button_number (button_number),
        .raw_byte      (raw_byte),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .last_of_run   (last_of_run)
    );

endmodule

[src/mpd_front.sv]
// mpd_front: accepts mouse bytes, tracks packet position and button history
// depends on mpd_pkg; emits one job_t per accepted word

module mpd_front
    import mpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output logic       job_write,
    output job_t       job
);

    byte_pos_t         pos_reg, pos_next;
    logic [7:0]        status_reg, status_next;
    logic signed [8:0] held_x_reg, held_x_next;
    logic [2:0]        prev_btn_reg, prev_btn_next;

    logic signed [8:0] dy;
    logic [2:0]        now_btn;
    logic [2:0]        press;
    logic [2:0]        release_mask;
    logic              move;

    // packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_STATUS;
            status_reg   <= '0;
            held_x_reg   <= '0;
            prev_btn_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            status_reg   <= status_next;
            held_x_reg   <= held_x_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    // button changes and y delta for a completing byte
    assign dy           = $signed({status_reg[5], data_byte});
    assign now_btn      = status_reg[2:0];
    assign press        = now_btn & ~prev_btn_reg;
    assign release_mask = prev_btn_reg & ~now_btn;
    assign move         = (held_x_reg != '0) || (dy != '0);

    // next state
    always_comb
    begin
        pos_next      = pos_reg;
        status_next   = status_reg;
        held_x_next   = held_x_reg;
        prev_btn_next = prev_btn_reg;
        if (accept)
        begin
            unique case (pos_reg)
                POS_X:
                begin
                    held_x_next = $signed({status_reg[4], data_byte});
                    pos_next    = POS_Y;
                end
                POS_Y:
                begin
                    prev_btn_next = now_btn;
                    pos_next      = POS_STATUS;
                end
                default:
                begin
                    status_next = data_byte;
                    pos_next    = POS_X;
                end
            endcase
        end
    end

    // job word for the back end
    always_comb
    begin
        job_write = accept;
        job.raw   = data_byte;
        job.dx    = held_x_reg;
        job.dy    = dy;
        job.pend  = '0;
        job.pend[SLOT_ECHO] = 1'b1;
        unique case (pos_reg)
            POS_Y:
            begin
                job.pend[SLOT_PRESS0 +: NUM_BUTTONS]   = press;
                job.pend[SLOT_RELEASE0 +: NUM_BUTTONS] = release_mask;
                job.pend[SLOT_MOVE]                    = move;
            end
            default:
            begin
                job.pend[SLOT_MOVE] = 1'b0;
            end
        endcase
    end

endmodule

[src/mpd_queue.sv]
// mpd_queue: short job queue decoupling the front and back of the decoder
// depends on mpd_pkg for job_t

module mpd_queue
    import mpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/mpd_back.sv]
// mpd_back: serializes each job into result words, one per cycle unless a word waits unpopped
// depends on mpd_pkg; feeds the output register seen on the result ports

module mpd_back
    import mpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  job_t              q_data,
    output logic              q_read,
    output logic              out_valid,
    input  logic              out_take,
    output logic [1:0]        event_kind,
    output logic [1:0]        button_number,
    output logic [7:0]        raw_byte,
    output logic signed [8:0] delta_x,
    output logic signed [8:0] delta_y,
    output logic              last_of_run
);

    logic [NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [7:0]           raw_reg;
    logic signed [8:0]    dx_reg, dy_reg;

    logic                 out_valid_reg, out_valid_next;
    event_kind_t          kind_reg, kind_next;
    logic [1:0]           btn_reg, btn_next;
    logic [7:0]           oraw_reg, oraw_next;
    logic signed [8:0]    odx_reg, odx_next;
    logic signed [8:0]    ody_reg, ody_next;
    logic                 olast_reg, olast_next;

    logic [SLOT_W-1:0]    sel_idx;
    logic                 found;
    logic [NUM_SLOTS-1:0] rest;
    logic                 active, advance, emit;

    // lowest pending slot goes out first
    always_comb
    begin
        sel_idx = '0;
        found   = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (!found && pend_reg[i])
            begin
                sel_idx = SLOT_W'(i);
                found   = 1'b1;
            end
        end
    end

    assign active  = |pend_reg;
    assign rest    = pend_reg & ~(NUM_SLOTS'(1) << sel_idx);
    assign advance = !out_valid_reg || out_take;
    assign emit    = active && advance;
    assign q_read  = !q_empty && (!active || (emit && (rest == '0)));

    // result word for the selected slot
    always_comb
    begin
        kind_next      = kind_reg;
        btn_next       = btn_reg;
        oraw_next      = oraw_reg;
        odx_next       = odx_reg;
        ody_next       = ody_reg;
        olast_next     = olast_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            olast_next     = (rest == '0);
            btn_next       = '0;
            oraw_next      = '0;
            odx_next       = '0;
            ody_next       = '0;
            priority if (sel_idx == SLOT_W'(SLOT_ECHO))
            begin
                kind_next = EV_RAW;
                oraw_next = raw_reg;
            end
            else if (sel_idx < SLOT_W'(SLOT_RELEASE0))
            begin
                kind_next = EV_PRESS;
                btn_next  = 2'(sel_idx - SLOT_W'(SLOT_PRESS0) + 1'b1);
            end
            else if (sel_idx < SLOT_W'(SLOT_MOVE))
            begin
                kind_next = EV_RELEASE;
                btn_next  = 2'(sel_idx - SLOT_W'(SLOT_RELEASE0) + 1'b1);
            end
            else
            begin
                kind_next = EV_MOVE;
                odx_next  = dx_reg;
                ody_next  = dy_reg;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // pending mask: drain, then reload from the queue
    always_comb
    begin
        pend_next = pend_reg;
        if (emit)
        begin
            pend_next = rest;
        end
        if (q_read)
        begin
            pend_next = q_data.pend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_read)
        begin
            raw_reg <= q_data.raw;
            dx_reg  <= q_data.dx;
            dy_reg  <= q_data.dy;
        end
        kind_reg  <= kind_next;
        btn_reg   <= btn_next;
        oraw_reg  <= oraw_next;
        odx_reg   <= odx_next;
        ody_reg   <= ody_next;
        olast_reg <= olast_next;
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign button_number = btn_reg;
    assign raw_byte      = oraw_reg;
    assign delta_x       = odx_reg;
    assign delta_y       = ody_reg;
    assign last_of_run   = olast_reg;

endmodule

[src/mpd_checker.sv]
// mpd_checker: port-level checks on the decoder's result words
// depends on mpd_pkg; bound to mouse_packet_decoder_core below

module mpd_checker
    import mpd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [1:0]        event_kind,
    input logic [1:0]        button_number,
    input logic [7:0]        raw_byte,
    input logic signed [8:0] delta_x,
    input logic signed [8:0] delta_y,
    input logic              last_of_run
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(event_kind) && $stable(raw_byte)
            && $stable(delta_x) && $stable(delta_y) && $stable(last_of_run))
        else $error("result word changed while stalled");

    // a move word ends its run and carries motion
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && event_kind == EV_MOVE |->
            last_of_run && button_number == '0 && raw_byte == '0
            && (delta_x != '0 || delta_y != '0))
        else $error("bad move word");

    // button words name a button and carry nothing else
    a_button: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (event_kind == EV_PRESS || event_kind == EV_RELEASE) |->
            button_number != '0 && raw_byte == '0 && delta_x == '0 && delta_y == '0)
        else $error("bad button word");

    // a raw echo carries no button or motion
    a_raw: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && event_kind == EV_RAW |->
            button_number == '0 && delta_x == '0 && delta_y == '0)
        else $error("bad raw echo word");

endmodule

bind mouse_packet_decoder_core mpd_checker u_mpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .event_kind    (event_kind),
    .button_number (button_number),
    .raw_byte      (raw_byte),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .last_of_run   (last_of_run)
);
